### rtl/core/htfd_pkg.sv
// ============================================================================
// htfd_pkg: shared types, constants and functions of the frame decoder
// Holds the CRC-8 byte step, the fixed-point scaling and the status codes.
// ============================================================================
package htfd_pkg;

   localparam int ByteWidth    = 8;
   localparam int RawWidth     = 16;
   localparam int TempWidth    = 15;
   localparam int HumWidth     = 14;
   localparam int StatusWidth  = 2;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth = 15;
   localparam int RspDataWidth = 32;

   localparam logic [ByteWidth-1:0] CrcPoly = 8'h31;
   localparam logic [ByteWidth-1:0] CrcInit = 8'hFF;

   localparam int TempScale  = 17500;
   localparam int HumScale   = 10000;
   localparam int FullScale  = 65535;
   localparam int TempOffset = 4500;

   localparam logic signed [TempWidth-1:0] TempLowReset  = -15'sd2000;
   localparam logic signed [TempWidth-1:0] TempHighReset = 15'sd12500;
   localparam logic [HumWidth-1:0]         HumLowReset   = 14'd0;
   localparam logic [HumWidth-1:0]         HumHighReset  = 14'd10000;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_UPDATED,
      STATUS_TEMP_CRC_BAD,
      STATUS_HUM_CRC_BAD,
      STATUS_OUT_OF_RANGE
   } status_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_TEMP_LOW,
      CSR_TEMP_HIGH,
      CSR_HUM_LOW,
      CSR_HUM_HIGH
   } csr_index_type;

   typedef enum logic [2:0] {
      POS_TEMP_HIGH,
      POS_TEMP_LOW,
      POS_TEMP_CRC,
      POS_HUM_HIGH,
      POS_HUM_LOW,
      POS_HUM_CRC
   } pos_type;

   typedef struct packed {
      logic signed [TempWidth-1:0] temp_low;
      logic signed [TempWidth-1:0] temp_high;
      logic [HumWidth-1:0]         hum_low;
      logic [HumWidth-1:0]         hum_high;
   } limits_type;

   typedef struct packed {
      logic                        emit;
      logic signed [TempWidth-1:0] temperature_centi;
      logic [HumWidth-1:0]         humidity_centi;
      status_type                  frame_status;
   } result_type;

   // CRC-8, MSB first, one byte folded in.
   function automatic logic [ByteWidth-1:0] crc8_byte(input logic [ByteWidth-1:0] crc,
                                                      input logic [ByteWidth-1:0] data);
      logic [ByteWidth-1:0] c;
      c = crc ^ data;
      for (int i = 0; i < ByteWidth; i++) begin
         c = c[ByteWidth-1] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      return c;
   endfunction

   // floor(17500*raw/65535) - 4500. The quotient by 65535 is taken as the
   // upper half of the product plus one correction step, since
   // x = q0*65535 + (q0 + lo) and that remainder stays below 2*65535.
   function automatic logic signed [TempWidth-1:0] scale_temp(input logic [RawWidth-1:0] raw);
      logic [30:0]          prod;
      logic [TempWidth-1:0] q0;
      logic [16:0]          rem;
      logic [TempWidth-1:0] q;
      prod = 31'(TempScale) * {15'd0, raw};
      q0   = prod[30:16];
      rem  = {1'b0, prod[15:0]} + {2'b0, q0};
      q    = q0 + TempWidth'(rem >= 17'(FullScale));
      return $signed(q - TempWidth'(TempOffset));
   endfunction

   // floor(10000*raw/65535), same correction scheme.
   function automatic logic [HumWidth-1:0] scale_hum(input logic [RawWidth-1:0] raw);
      logic [29:0]         prod;
      logic [HumWidth-1:0] q0;
      logic [16:0]         rem;
      prod = 30'(HumScale) * {14'd0, raw};
      q0   = prod[29:16];
      rem  = {1'b0, prod[15:0]} + {3'b0, q0};
      return q0 + HumWidth'(rem >= 17'(FullScale));
   endfunction

endpackage

### rtl/core/htfd_csr.sv
// ============================================================================
// htfd_csr: limit registers
// Four write-only limit registers loaded from the configuration channel.
// ============================================================================
module htfd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [htfd_pkg::CsrIndexWidth-1:0]   wr_index,
   input  logic [htfd_pkg::CsrDataWidth-1:0]    wr_data,
   output htfd_pkg::limits_type                 limits
);

   htfd_pkg::limits_type limits_ff;
   htfd_pkg::limits_type limits_in;

   always_comb begin
      limits_in = limits_ff;
      if (wr_en) begin
         unique case (htfd_pkg::csr_index_type'(wr_index))
            htfd_pkg::CSR_TEMP_LOW:  limits_in.temp_low  = $signed(wr_data);
            htfd_pkg::CSR_TEMP_HIGH: limits_in.temp_high = $signed(wr_data);
            htfd_pkg::CSR_HUM_LOW:   limits_in.hum_low   = wr_data[htfd_pkg::HumWidth-1:0];
            htfd_pkg::CSR_HUM_HIGH:  limits_in.hum_high  = wr_data[htfd_pkg::HumWidth-1:0];
            default:                 limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.temp_low  <= htfd_pkg::TempLowReset;
         limits_ff.temp_high <= htfd_pkg::TempHighReset;
         limits_ff.hum_low   <= htfd_pkg::HumLowReset;
         limits_ff.hum_high  <= htfd_pkg::HumHighReset;
      end else begin
         limits_ff <= limits_in;
      end
   end

   assign limits = limits_ff;

endmodule

### rtl/core/htfd_core.sv
// ============================================================================
// htfd_core: frame tracking, CRC checking and conversion
// Consumes one registered byte per step and produces the frame result.
// ============================================================================
module htfd_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic [htfd_pkg::ByteWidth-1:0]   data_byte,
   input  logic                             frame_start,
   input  htfd_pkg::limits_type             limits,
   output htfd_pkg::result_type             result
);

   htfd_pkg::pos_type                     pos_ff, pos_in, pos;
   logic [htfd_pkg::ByteWidth-1:0]        crc_ff, crc_in;
   logic [htfd_pkg::RawWidth-1:0]         temp_raw_ff, temp_raw_in;
   logic [htfd_pkg::RawWidth-1:0]         hum_raw_ff, hum_raw_in;
   logic                                  temp_ok_ff, temp_ok_in;
   logic signed [htfd_pkg::TempWidth-1:0] held_temp_ff, held_temp_in;
   logic [htfd_pkg::HumWidth-1:0]         held_hum_ff, held_hum_in;
   logic signed [htfd_pkg::TempWidth-1:0] temp_scaled;
   logic [htfd_pkg::HumWidth-1:0]         hum_scaled;
   logic                                  hum_crc_ok;
   logic                                  out_of_range;
   htfd_pkg::status_type                  status;

   // Frame position: a start flag forces byte zero, otherwise the count
   // advances and wraps after the humidity check byte.
   always_comb begin
      pos = (frame_start || pos_ff > htfd_pkg::POS_HUM_CRC) ? htfd_pkg::POS_TEMP_HIGH : pos_ff;
      unique case (pos)
         htfd_pkg::POS_TEMP_HIGH: pos_in = htfd_pkg::POS_TEMP_LOW;
         htfd_pkg::POS_TEMP_LOW:  pos_in = htfd_pkg::POS_TEMP_CRC;
         htfd_pkg::POS_TEMP_CRC:  pos_in = htfd_pkg::POS_HUM_HIGH;
         htfd_pkg::POS_HUM_HIGH:  pos_in = htfd_pkg::POS_HUM_LOW;
         htfd_pkg::POS_HUM_LOW:   pos_in = htfd_pkg::POS_HUM_CRC;
         htfd_pkg::POS_HUM_CRC:   pos_in = htfd_pkg::POS_TEMP_HIGH;
         default:                 pos_in = htfd_pkg::POS_TEMP_HIGH;
      endcase
   end

   always_comb begin
      temp_scaled  = htfd_pkg::scale_temp(temp_raw_ff);
      hum_scaled   = htfd_pkg::scale_hum(hum_raw_ff);
      hum_crc_ok   = (crc_ff == data_byte);
      out_of_range = (temp_scaled < limits.temp_low) || (temp_scaled > limits.temp_high) ||
                     (hum_scaled < limits.hum_low) || (hum_scaled > limits.hum_high);

      crc_in       = crc_ff;
      temp_raw_in  = temp_raw_ff;
      hum_raw_in   = hum_raw_ff;
      temp_ok_in   = temp_ok_ff;
      held_temp_in = held_temp_ff;
      held_hum_in  = held_hum_ff;
      status       = htfd_pkg::STATUS_UPDATED;
      result.emit  = 1'b0;

      unique case (pos)
         htfd_pkg::POS_TEMP_HIGH: begin
            crc_in      = htfd_pkg::crc8_byte(htfd_pkg::CrcInit, data_byte);
            temp_raw_in = {data_byte, temp_raw_ff[7:0]};
         end
         htfd_pkg::POS_TEMP_LOW: begin
            crc_in      = htfd_pkg::crc8_byte(crc_ff, data_byte);
            temp_raw_in = {temp_raw_ff[15:8], data_byte};
         end
         htfd_pkg::POS_TEMP_CRC: begin
            temp_ok_in = (crc_ff == data_byte);
            crc_in     = htfd_pkg::CrcInit;
         end
         htfd_pkg::POS_HUM_HIGH: begin
            crc_in     = htfd_pkg::crc8_byte(htfd_pkg::CrcInit, data_byte);
            hum_raw_in = {data_byte, hum_raw_ff[7:0]};
         end
         htfd_pkg::POS_HUM_LOW: begin
            crc_in     = htfd_pkg::crc8_byte(crc_ff, data_byte);
            hum_raw_in = {hum_raw_ff[15:8], data_byte};
         end
         htfd_pkg::POS_HUM_CRC: begin
            crc_in      = htfd_pkg::CrcInit;
            result.emit = 1'b1;
            // The temperature check wins when both words are corrupt.
            priority if (!temp_ok_ff) begin
               status = htfd_pkg::STATUS_TEMP_CRC_BAD;
            end else if (!hum_crc_ok) begin
               status = htfd_pkg::STATUS_HUM_CRC_BAD;
            end else if (out_of_range) begin
               status = htfd_pkg::STATUS_OUT_OF_RANGE;
            end else begin
               status       = htfd_pkg::STATUS_UPDATED;
               held_temp_in = temp_scaled;
               held_hum_in  = hum_scaled;
            end
         end
         default: begin
            crc_in = crc_ff;
         end
      endcase

      result.temperature_centi = held_temp_in;
      result.humidity_centi    = held_hum_in;
      result.frame_status      = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= htfd_pkg::POS_TEMP_HIGH;
         crc_ff       <= htfd_pkg::CrcInit;
         temp_raw_ff  <= '0;
         hum_raw_ff   <= '0;
         temp_ok_ff   <= 1'b0;
         held_temp_ff <= '0;
         held_hum_ff  <= '0;
      end else if (step) begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         temp_raw_ff  <= temp_raw_in;
         hum_raw_ff   <= hum_raw_in;
         temp_ok_ff   <= temp_ok_in;
         held_temp_ff <= held_temp_in;
         held_hum_ff  <= held_hum_in;
      end
   end

endmodule

### rtl/core/humidity_temp_frame_decoder.sv
// ============================================================================
// humidity_temp_frame_decoder: sensor measurement frame decoder
// Checks the two CRC-8 words of a six-byte frame and converts the readings.
// ============================================================================
// The req channel carries one frame byte per beat in req_tdata; req_tuser set
// marks the beat as the first byte of a frame and resynchronizes the byte
// counter. The frame order is temperature high, low, CRC, then humidity high,
// low, CRC. Only the sixth byte produces an rsp beat; it carries the held
// temperature and humidity (updated only when both CRCs match and both values
// lie within the limits) and a status code.
// The csr channel writes the four limit registers; it is always ready and
// should only be used while no frame is in flight.
// Each accepted beat is registered, processed in one pass of combinational
// logic (CRC byte step, constant multiply and reciprocal correction, limit
// compares) and the result lands in the output register. The rsp beat for a
// sixth byte passes from the input register to the output register as soon as
// the output register is free or being emptied. One byte is accepted
// every cycle while the receiver keeps up.
// When rsp_tready is low the result register holds its beat; the input
// register still takes one more byte, and req_tready falls only when both
// registers are full. Reset empties both registers and returns the frame
// position, CRC and held readings to their initial values and the limits to
// their defaults.
module humidity_temp_frame_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input beats.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [htfd_pkg::ByteWidth-1:0]       req_tdata,   // [7:0] data_byte
   input  logic                                 req_tuser,   // [0] frame_start
   // Result beats.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [14:0] temperature_centi, [28:15] humidity_centi, [30:29] frame_status,
   // [31] zero
   output logic [htfd_pkg::RspDataWidth-1:0]    rsp_tdata,
   // Limit register writes.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [htfd_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [htfd_pkg::CsrDataWidth-1:0]    csr_data
);

   localparam int PadWidth = htfd_pkg::RspDataWidth - htfd_pkg::TempWidth -
                             htfd_pkg::HumWidth - htfd_pkg::StatusWidth;

   logic                              in_valid_ff, in_valid_in;
   logic [htfd_pkg::ByteWidth-1:0]    in_byte_ff;
   logic                              in_start_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [htfd_pkg::RspDataWidth-1:0] rsp_data_ff;
   logic                              req_accept;
   logic                              advance;
   htfd_pkg::limits_type              limits;
   htfd_pkg::result_type              result;

   // The input stage moves on whenever the output register is free or being
   // emptied in this cycle.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   htfd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .limits   (limits)
   );

   htfd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .data_byte   (in_byte_ff),
      .frame_start (in_start_ff),
      .limits      (limits),
      .result      (result)
   );

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = result.emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
      if (advance && result.emit) begin
         rsp_data_ff <= {{PadWidth{1'b0}}, result.frame_status, result.humidity_centi,
                         result.temperature_centi};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/core/htfd_checker.sv
// ============================================================================
// htfd_checker: port-level checks of the frame decoder
// Watches reset behavior, result holding, result ranges and input flow.
// ============================================================================
module htfd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [htfd_pkg::RspDataWidth-1:0] rsp_tdata
);

   // No result beat may be left over from before reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // A stalled result beat stays presented and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp beat changed");

   // Held temperature only ever takes converted values or its reset value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[14:0]) >= -15'sd4500) &&
                     ($signed(rsp_tdata[14:0]) <= 15'sd13000))
      else $error("temperature out of conversion range");

   // Held humidity stays within full scale and the pad bit stays clear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[28:15] <= 14'd10000) && !rsp_tdata[31])
      else $error("humidity out of range or pad bit set");

   // With the output register empty the input side can never be blocked.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output register");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
